// ----- hw/rtl/q2e_pkg.sv -----
// Shared constants, types and the arctangent table for the quaternion to Euler converter.
package q2e_pkg;

	localparam int CORDIC_STAGES  = 16;
	localparam int COMPONENT_BITS = 16;

	localparam int PROD_FRAC = 30;
	localparam int WORK_FRAC = COMPONENT_BITS + 6;
	localparam int SHIFT_DN  = PROD_FRAC - WORK_FRAC;
	localparam int OPD_W     = 34;
	localparam int CW        = WORK_FRAC + 8;
	localparam int ACC_W     = 34;
	localparam int TABLE_LEN = 24;
	localparam int STAGE_W   = 5;

	localparam int ISQ_STEPS = 31;
	localparam int RAD_W     = 62;
	localparam int TOP_BIT   = 2 * (ISQ_STEPS - 1);

	localparam int GIMBAL_LIMIT = 536870375;
	localparam int HALF_TURN    = 1800000000;

	localparam int ROUND_BIAS = 50000;
	localparam int PRE_SHIFT  = 5;
	localparam int U_W        = 26;
	localparam int DIV_MUL_W  = 27;
	localparam logic [DIV_MUL_W-1:0] DIV_MUL = 27'd87960931;
	localparam int DIV_SHIFT  = 38;
	localparam int Q_W        = 15;

	localparam logic [Q_W-1:0]   PITCH_LIM = 15'd9000;
	localparam logic [Q_W-1:0]   ROT_LIM   = 15'd18000;
	localparam logic [ACC_W-1:0] PITCH_SAT = 34'd900100000;
	localparam logic [ACC_W-1:0] ROT_SAT   = 34'd1800100000;

	typedef logic signed [OPD_W-1:0] opd_t;

	typedef struct packed {
		logic              zero;
		logic signed [CW-1:0]    x;
		logic signed [CW-1:0]    y;
		logic signed [ACC_W-1:0] acc;
	} cordic_t;

	typedef struct packed {
		logic [RAD_W-1:0] n;
		logic [RAD_W-1:0] res;
	} isq_t;

	function automatic logic signed [ACC_W-1:0] atan_step(input logic [STAGE_W-1:0] i);
		logic signed [ACC_W-1:0] r;
		case (i)
			5'd0:    r = 34'sd450000000;
			5'd1:    r = 34'sd265650512;
			5'd2:    r = 34'sd140362435;
			5'd3:    r = 34'sd71250163;
			5'd4:    r = 34'sd35763344;
			5'd5:    r = 34'sd17899106;
			5'd6:    r = 34'sd8951737;
			5'd7:    r = 34'sd4476142;
			5'd8:    r = 34'sd2238105;
			5'd9:    r = 34'sd1119057;
			5'd10:   r = 34'sd559529;
			5'd11:   r = 34'sd279765;
			5'd12:   r = 34'sd139882;
			5'd13:   r = 34'sd69941;
			5'd14:   r = 34'sd34971;
			5'd15:   r = 34'sd17485;
			5'd16:   r = 34'sd8743;
			5'd17:   r = 34'sd4371;
			5'd18:   r = 34'sd2186;
			5'd19:   r = 34'sd1093;
			5'd20:   r = 34'sd546;
			5'd21:   r = 34'sd273;
			5'd22:   r = 34'sd137;
			5'd23:   r = 34'sd68;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/q2e_isqrt_cell.sv -----
// One digit step of the pipelined integer square root.
module q2e_isqrt_cell (
	input  logic                   clk,
	input  logic                   en,
	input  logic [4:0]             step,
	input  q2e_pkg::isq_t          d,
	output q2e_pkg::isq_t          q
);
	import q2e_pkg::*;

	logic [RAD_W-1:0] bitv;
	logic [RAD_W-1:0] sum;
	logic [5:0]       shamt;
	isq_t             nxt;
	isq_t             cell_q;

	always_comb begin
		shamt = 6'(TOP_BIT) - {step, 1'b0};
		bitv  = RAD_W'(1) << shamt;
		sum   = d.res + bitv;
		if (d.n >= sum) begin
			nxt.n   = d.n - sum;
			nxt.res = (d.res >> 1) + bitv;
		end else begin
			nxt.n   = d.n;
			nxt.res = d.res >> 1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;
endmodule

// ----- hw/rtl/q2e_cordic_cell.sv -----
// One vectoring rotation of the CORDIC chain.
module q2e_cordic_cell (
	input  logic                        clk,
	input  logic                        en,
	input  logic [q2e_pkg::STAGE_W-1:0] step,
	input  q2e_pkg::cordic_t            d,
	output q2e_pkg::cordic_t            q
);
	import q2e_pkg::*;

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	cordic_t              nxt;
	cordic_t              cell_q;

	always_comb begin
		dx = d.y >>> step;
		dy = d.x >>> step;
		nxt.zero = d.zero;
		if (!d.y[CW-1] && (d.y != '0)) begin
			nxt.x   = d.x + dx;
			nxt.y   = d.y - dy;
			nxt.acc = d.acc + atan_step(step);
		end else begin
			nxt.x   = d.x - dx;
			nxt.y   = d.y + dy;
			nxt.acc = d.acc - atan_step(step);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= nxt;
		end
	end

	assign q = cell_q;
endmodule

// ----- hw/rtl/q2e_cordic.sv -----
// atan2 unit: operand scaling and quadrant fold, then the chain of CORDIC cells.
module q2e_cordic (
	input  logic                             clk,
	input  logic                             en,
	input  q2e_pkg::opd_t                    num,
	input  q2e_pkg::opd_t                    den,
	output logic signed [q2e_pkg::ACC_W-1:0] angle
);
	import q2e_pkg::*;

	localparam logic signed [OPD_W:0] RND = (OPD_W + 1)'((2 ** SHIFT_DN) / 2);

	logic signed [OPD_W:0] ny_w;
	logic signed [OPD_W:0] dx_w;
	logic signed [CW-1:0]  ys;
	logic signed [CW-1:0]  xs;
	cordic_t               pre;
	cordic_t               pre_q;
	cordic_t               stg [CORDIC_STAGES+1];

	always_comb begin
		ny_w = ($signed({num[OPD_W-1], num}) + RND) >>> SHIFT_DN;
		dx_w = ($signed({den[OPD_W-1], den}) + RND) >>> SHIFT_DN;
		ys   = CW'(ny_w);
		xs   = CW'(dx_w);
		pre.zero = (xs == '0) && (ys == '0);
		if (xs[CW-1]) begin
			pre.x   = -xs;
			pre.y   = -ys;
			pre.acc = ys[CW-1] ? -ACC_W'(HALF_TURN) : ACC_W'(HALF_TURN);
		end else begin
			pre.x   = xs;
			pre.y   = ys;
			pre.acc = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pre_q <= pre;
		end
	end

	assign stg[0] = pre_q;

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		q2e_cordic_cell u_cell (
			.clk  (clk),
			.en   (en),
			.step (STAGE_W'(k)),
			.d    (stg[k]),
			.q    (stg[k+1])
		);
	end

	assign angle = stg[CORDIC_STAGES].zero ? '0 : stg[CORDIC_STAGES].acc;
endmodule

// ----- hw/rtl/q2e_round.sv -----
// Round an angle to hundredths of a degree and saturate it.
module q2e_round (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [q2e_pkg::ACC_W-1:0] angle,
	input  logic [q2e_pkg::Q_W-1:0]          limit,
	input  logic [q2e_pkg::ACC_W-1:0]        sat_at,
	output logic signed [q2e_pkg::Q_W:0]     result
);
	import q2e_pkg::*;

	logic [ACC_W-1:0]             mag;
	logic [ACC_W:0]               v;
	logic [U_W-1:0]               u_s1;
	logic                         sat_s1;
	logic                         neg_s1;
	logic [U_W+DIV_MUL_W-1:0]     prod_s2;
	logic                         sat_s2;
	logic                         neg_s2;
	logic [Q_W-1:0]               qv;
	logic [Q_W-1:0]               magq;

	always_comb begin
		mag = angle[ACC_W-1] ? ACC_W'(-angle) : ACC_W'(angle);
		v   = {1'b0, mag} + (ACC_W + 1)'(ROUND_BIAS);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= v[PRE_SHIFT +: U_W];
			sat_s1  <= v >= {1'b0, sat_at};
			neg_s1  <= angle[ACC_W-1];
			prod_s2 <= u_s1 * DIV_MUL;
			sat_s2  <= sat_s1;
			neg_s2  <= neg_s1;
		end
	end

	always_comb begin
		qv     = prod_s2[DIV_SHIFT +: Q_W];
		magq   = sat_s2 ? limit : qv;
		result = neg_s2 ? -$signed({1'b0, magq}) : $signed({1'b0, magq});
	end
endmodule

// ----- hw/rtl/quaternion_to_euler.sv -----
// Top level of the quaternion to Euler angle converter.
// Converts a Q1.15 quaternion to pitch, yaw and roll in hundredths of a degree.
// One quaternion word is taken every cycle; each word passes through four
// product and sum stages, 31 square-root cells, one fold stage plus one
// cell per CORDIC rotation, two rounding stages and the output register.
// Stall on the output holds the whole pipeline; a word is taken whenever
// the output register is empty or is being read in the same cycle.
module quaternion_to_euler (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	input  logic signed [15:0] quat_w,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [14:0] angle_about_x,
	output logic signed [15:0] angle_about_y,
	output logic signed [15:0] angle_about_z,
	output logic               gimbal_clamped
);
	import q2e_pkg::*;

	localparam int PIPE = ISQ_STEPS + CORDIC_STAGES + 7;
	localparam int GD   = ISQ_STEPS + CORDIC_STAGES + 4;

	typedef struct packed {
		opd_t roll_num;
		opd_t roll_den;
		opd_t yaw_num;
		opd_t yaw_den;
		opd_t pit_num;
	} side_t;

	typedef struct packed {
		logic pos;
		logic neg;
	} gim_t;

	logic en;
	logic [PIPE-1:0] vld_q;
	logic out_valid_q;

	logic signed [31:0] wz_s1, xy_s1, zz_s1, xx_s1, wy_s1, xz_s1, yy_s1, wx_s1, yz_s1;
	opd_t               roll_num_s2, roll_den_s2, yaw_num_s2, yaw_den_s2;
	logic signed [32:0] p_s2;
	side_t              side_s3;
	logic [60:0]        msq_s3;
	gim_t               gim_s3;
	logic [32:0]        pabs;
	logic [31:0]        m;
	side_t              side_s4;
	logic [RAD_W-1:0]   rad_s4;
	side_t              side_q [ISQ_STEPS];
	gim_t               gim_q [GD];
	isq_t               isq [ISQ_STEPS+1];

	logic signed [ACC_W-1:0] ang_pit, ang_yaw, ang_roll;
	logic signed [Q_W:0]     r_pit, r_yaw, r_roll;

	logic signed [14:0] ax_q;
	logic signed [15:0] ay_q;
	logic signed [15:0] az_q;
	logic               gim_out_q;

	assign en       = !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_q       <= {vld_q[PIPE-2:0], in_valid};
			out_valid_q <= vld_q[PIPE-1];
		end
	end

	always_comb begin
		pabs = p_s2[32] ? 33'(-p_s2) : 33'(p_s2);
		m    = {pabs[30:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wz_s1 <= quat_w * quat_z;
			xy_s1 <= quat_x * quat_y;
			zz_s1 <= quat_z * quat_z;
			xx_s1 <= quat_x * quat_x;
			wy_s1 <= quat_w * quat_y;
			xz_s1 <= quat_x * quat_z;
			yy_s1 <= quat_y * quat_y;
			wx_s1 <= quat_w * quat_x;
			yz_s1 <= quat_y * quat_z;

			roll_num_s2 <= (OPD_W'(wz_s1) + OPD_W'(xy_s1)) <<< 1;
			roll_den_s2 <= (OPD_W'(1) <<< PROD_FRAC) - ((OPD_W'(zz_s1) + OPD_W'(xx_s1)) <<< 1);
			yaw_num_s2  <= (OPD_W'(wy_s1) + OPD_W'(xz_s1)) <<< 1;
			yaw_den_s2  <= (OPD_W'(1) <<< PROD_FRAC) - ((OPD_W'(xx_s1) + OPD_W'(yy_s1)) <<< 1);
			p_s2        <= 33'(wx_s1) - 33'(yz_s1);

			side_s3.roll_num <= roll_num_s2;
			side_s3.roll_den <= roll_den_s2;
			side_s3.yaw_num  <= yaw_num_s2;
			side_s3.yaw_den  <= yaw_den_s2;
			side_s3.pit_num  <= OPD_W'(p_s2) <<< 1;
			msq_s3           <= 61'(m * m);
			gim_s3.pos       <= p_s2 > 33'sd536870375;
			gim_s3.neg       <= p_s2 < -33'sd536870375;

			side_s4 <= side_s3;
			rad_s4  <= (RAD_W'(1) << TOP_BIT) - RAD_W'(msq_s3);

			side_q[0] <= side_s4;
			for (int k = 1; k < ISQ_STEPS; k++) begin
				side_q[k] <= side_q[k-1];
			end
			gim_q[0] <= gim_s3;
			for (int k = 1; k < GD; k++) begin
				gim_q[k] <= gim_q[k-1];
			end
		end
	end

	assign isq[0].n   = rad_s4;
	assign isq[0].res = '0;

	for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_isq
		q2e_isqrt_cell u_isq (
			.clk  (clk),
			.en   (en),
			.step (5'(k)),
			.d    (isq[k]),
			.q    (isq[k+1])
		);
	end

	q2e_cordic u_cordic_pit (
		.clk   (clk),
		.en    (en),
		.num   (side_q[ISQ_STEPS-1].pit_num),
		.den   (OPD_W'(isq[ISQ_STEPS].res)),
		.angle (ang_pit)
	);

	q2e_cordic u_cordic_yaw (
		.clk   (clk),
		.en    (en),
		.num   (side_q[ISQ_STEPS-1].yaw_num),
		.den   (side_q[ISQ_STEPS-1].yaw_den),
		.angle (ang_yaw)
	);

	q2e_cordic u_cordic_roll (
		.clk   (clk),
		.en    (en),
		.num   (side_q[ISQ_STEPS-1].roll_num),
		.den   (side_q[ISQ_STEPS-1].roll_den),
		.angle (ang_roll)
	);

	q2e_round u_round_pit (
		.clk    (clk),
		.en     (en),
		.angle  (ang_pit),
		.limit  (PITCH_LIM),
		.sat_at (PITCH_SAT),
		.result (r_pit)
	);

	q2e_round u_round_yaw (
		.clk    (clk),
		.en     (en),
		.angle  (ang_yaw),
		.limit  (ROT_LIM),
		.sat_at (ROT_SAT),
		.result (r_yaw)
	);

	q2e_round u_round_roll (
		.clk    (clk),
		.en     (en),
		.angle  (ang_roll),
		.limit  (ROT_LIM),
		.sat_at (ROT_SAT),
		.result (r_roll)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			if (gim_q[GD-1].pos) begin
				ax_q <= 15'sd9000;
			end else if (gim_q[GD-1].neg) begin
				ax_q <= -15'sd9000;
			end else begin
				ax_q <= 15'(r_pit);
			end
			ay_q      <= r_yaw;
			az_q      <= r_roll;
			gim_out_q <= gim_q[GD-1].pos || gim_q[GD-1].neg;
		end
	end

	assign out_valid      = out_valid_q;
	assign angle_about_x  = ax_q;
	assign angle_about_y  = ay_q;
	assign angle_about_z  = az_q;
	assign gimbal_clamped = gim_out_q;
endmodule
